### src/modified_utf7_decoder_top_defines.svh
// assertion macros for the modified utf-7 decoder checker
`ifndef MODIFIED_UTF7_DECODER_TOP_DEFINES_SVH
`define MODIFIED_UTF7_DECODER_TOP_DEFINES_SVH

// checked outside reset
`define MU7D_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked during reset as well
`define MU7D_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### src/mu7d_pkg.sv
// types, constants and helper functions shared by the decoder modules
`timescale 1ns / 1ps

package mu7d_pkg;

   typedef enum logic [1:0] {
      CMD_PASS,
      CMD_OPEN,
      CMD_STORE,
      CMD_CLOSE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
      logic         last;
   } cmd_type;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;

   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_DASH    = 8'h2D;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   localparam logic [15:0] HIGH_FIRST = 16'hD800;
   localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
   localparam logic [15:0] LOW_FIRST  = 16'hDC00;
   localparam logic [15:0] LOW_LAST   = 16'hDFFF;
   localparam logic [20:0] CP_PLANE1  = 21'h10000;

   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
   localparam logic [7:0] UTF8_CONT  = 8'h80;

   // {valid, six-bit value} of a modified base64 digit
   function automatic logic [6:0] digit_decode(input logic [7:0] c);
      logic [6:0] r;
      r = '0;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
         r = {1'b1, 6'(c - CHAR_UPPER_A)};
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
         r = {1'b1, 6'(c - CHAR_LOWER_A + 8'd26)};
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         r = {1'b1, 6'(c - CHAR_ZERO + 8'd52)};
      end else if (c == CHAR_PLUS) begin
         r = {1'b1, 6'd62};
      end else if (c == CHAR_COMMA) begin
         r = {1'b1, 6'd63};
      end
      return r;
   endfunction

   function automatic logic is_high(input logic [15:0] u);
      return (u >= HIGH_FIRST) && (u <= HIGH_LAST);
   endfunction

   function automatic logic is_low(input logic [15:0] u);
      return (u >= LOW_FIRST) && (u <= LOW_LAST);
   endfunction

   // utf-8 length minus one
   function automatic logic [1:0] utf8_len(input logic [20:0] cp);
      logic [1:0] r;
      if (cp < 21'h80) begin
         r = 2'd0;
      end else if (cp < 21'h800) begin
         r = 2'd1;
      end else if (cp < CP_PLANE1) begin
         r = 2'd2;
      end else begin
         r = 2'd3;
      end
      return r;
   endfunction

   function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] len_m1,
                                            input logic [1:0] pos);
      logic [1:0] grp;
      logic [5:0] six;
      logic [7:0] r;
      grp = len_m1 - pos;
      case (grp)
         2'd0:    six = cp[5:0];
         2'd1:    six = cp[11:6];
         2'd2:    six = cp[17:12];
         default: six = {3'b000, cp[20:18]};
      endcase
      if (pos == 2'd0) begin
         case (len_m1)
            2'd0:    r = {1'b0, cp[6:0]};
            2'd1:    r = UTF8_LEAD2 | {3'b000, cp[10:6]};
            2'd2:    r = UTF8_LEAD3 | {4'b0000, cp[15:12]};
            default: r = UTF8_LEAD4 | {5'b00000, cp[20:18]};
         endcase
      end else begin
         r = UTF8_CONT | {2'b00, six};
      end
      return r;
   endfunction

endpackage

### src/mu7d_front.sv
// front end: accepts name bytes, tracks the shift and classifies each beat
`timescale 1ns / 1ps

module mu7d_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_in_byte,
   input  logic              req_end_of_name,
   input  logic              fifo_full,
   output logic              push,
   output mu7d_pkg::cmd_type push_cmd
);

   logic in_shift_ff;
   logic in_shift_in;

   assign req_stall = fifo_full;
   assign push      = req_valid && !fifo_full;

   always_comb begin
      push_cmd.data = req_in_byte;
      push_cmd.last = req_end_of_name;
      push_cmd.kind = mu7d_pkg::CMD_PASS;
      in_shift_in   = in_shift_ff;
      if (!in_shift_ff) begin
         if (req_in_byte == mu7d_pkg::CHAR_AMP && !req_end_of_name) begin
            push_cmd.kind = mu7d_pkg::CMD_OPEN;
            in_shift_in   = 1'b1;
         end
      end else if (req_in_byte == mu7d_pkg::CHAR_DASH) begin
         push_cmd.kind = mu7d_pkg::CMD_CLOSE;
         in_shift_in   = 1'b0;
      end else begin
         push_cmd.kind = mu7d_pkg::CMD_STORE;
      end
      if (req_end_of_name) begin
         in_shift_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_shift_ff <= 1'b0;
      end else if (push) begin
         in_shift_ff <= in_shift_in;
      end
   end

endmodule

### src/mu7d_fifo.sv
// short command queue between front and back end
`timescale 1ns / 1ps

module mu7d_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mu7d_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output mu7d_pkg::cmd_type pop_cmd,
   output logic              empty
);

   localparam int CNTW = mu7d_pkg::FIFO_AW + 1;

   mu7d_pkg::cmd_type             entry_ff [mu7d_pkg::FIFO_DEPTH];
   logic [mu7d_pkg::FIFO_AW-1:0]  wr_ptr_ff;
   logic [mu7d_pkg::FIFO_AW-1:0]  rd_ptr_ff;
   logic [CNTW-1:0]               count_ff;
   logic [CNTW-1:0]               count_in;

   assign full    = count_ff == CNTW'(mu7d_pkg::FIFO_DEPTH);
   assign empty   = count_ff == '0;
   assign pop_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNTW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + mu7d_pkg::FIFO_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + mu7d_pkg::FIFO_AW'(1);
         end
         count_ff <= count_in;
      end
   end

endmodule

### src/mu7d_back.sv
// back end: body store, shift decode to utf-8 and the result register
`timescale 1ns / 1ps

module mu7d_back #(
   parameter int MAX_BODY = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fifo_empty,
   input  mu7d_pkg::cmd_type cmd,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_byte_valid,
   output logic              rsp_last_of_run,
   output logic              rsp_name_done,
   output logic              rsp_overflow
);

   localparam int CW = $clog2(MAX_BODY + 1);
   localparam int AW = $clog2(MAX_BODY);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_RAW_AMP,
      ST_RAW_BODY,
      ST_RAW_DASH,
      ST_DECODE,
      ST_EMIT,
      ST_FLUSH,
      ST_FIN
   } state_type;

   logic [7:0] body_mem [MAX_BODY];
   logic [7:0] rd_data_ff;

   state_type   state_ff, state_in;
   state_type   ret_ff, ret_in;
   logic [CW-1:0] count_ff, count_in;
   logic        ovf_ff, ovf_in;
   logic        run_ovf_ff, run_ovf_in;
   logic        dash_ff, dash_in;
   logic        end_ff, end_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic        rd_ok_ff, rd_ok_in;
   logic        rd_last_ff, rd_last_in;
   logic [13:0] acc_ff, acc_in;
   logic [2:0]  bits_ff, bits_in;
   logic [7:0]  hi_ff, hi_in;
   logic        have_hi_ff, have_hi_in;
   logic [15:0] pend_ff, pend_in;
   logic        pend_valid_ff, pend_valid_in;
   logic [20:0] cp_ff, cp_in;
   logic [1:0]  len_ff, len_in;
   logic [1:0]  pos_ff, pos_in;
   logic        hold_valid_ff, hold_valid_in;
   logic [7:0]  hold_byte_ff, hold_byte_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte_ff, rsp_byte_in;
   logic        rsp_bv_ff, rsp_bv_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        rsp_done_ff, rsp_done_in;
   logic        rsp_ovf_ff, rsp_ovf_in;

   logic        step;
   logic        rd_en;
   logic        wr_en;
   logic        put_en;
   logic [7:0]  put_val;
   logic        fin_en;
   logic [6:0]  digit;
   logic [13:0] acc_next;
   logic [3:0]  bits_sum;
   logic        byte_ready;
   logic [2:0]  byte_shift;
   logic [7:0]  new_byte;
   logic [15:0] unit;
   logic        unit_ready;
   logic        unit_high;
   logic        unit_low;
   logic        u_emit;
   logic [20:0] u_cp;
   logic        u_pend_valid;
   logic [15:0] u_pend;

   assign step       = !rsp_valid_ff || !rsp_stall;
   assign digit      = mu7d_pkg::digit_decode(rd_data_ff);
   assign acc_next   = {acc_ff[7:0], digit[5:0]};
   assign bits_sum   = {1'b0, bits_ff} + 4'd6;
   assign byte_ready = bits_sum >= 4'd8;
   assign byte_shift = 3'(bits_sum - 4'd8);
   assign new_byte   = 8'(acc_next >> byte_shift);
   assign unit       = {hi_ff, new_byte};
   assign unit_ready = byte_ready && have_hi_ff;
   assign unit_high  = mu7d_pkg::is_high(unit);
   assign unit_low   = mu7d_pkg::is_low(unit);

   // surrogate pairing of a finished utf-16 unit
   always_comb begin
      u_emit       = 1'b0;
      u_cp         = {5'b00000, unit};
      u_pend_valid = pend_valid_ff;
      u_pend       = pend_ff;
      if (unit_ready) begin
         if (pend_valid_ff && unit_low) begin
            u_emit       = 1'b1;
            u_cp         = mu7d_pkg::CP_PLANE1 + 21'({pend_ff[9:0], unit[9:0]});
            u_pend_valid = 1'b0;
         end else begin
            u_pend_valid = 1'b0;
            if (unit_high) begin
               u_pend       = unit;
               u_pend_valid = 1'b1;
            end else if (!unit_low) begin
               u_emit = 1'b1;
            end
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      run_ovf_in    = run_ovf_ff;
      dash_in       = dash_ff;
      end_in        = end_ff;
      rd_idx_in     = rd_idx_ff;
      rd_ok_in      = rd_ok_ff;
      rd_last_in    = rd_last_ff;
      acc_in        = acc_ff;
      bits_in       = bits_ff;
      hi_in         = hi_ff;
      have_hi_in    = have_hi_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      cp_in         = cp_ff;
      len_in        = len_ff;
      pos_in        = pos_ff;
      hold_valid_in = hold_valid_ff;
      hold_byte_in  = hold_byte_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_bv_in     = rsp_bv_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      pop           = 1'b0;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      put_en        = 1'b0;
      put_val       = '0;
      fin_en        = 1'b0;

      if (step) begin
         rsp_valid_in = 1'b0;

         // body walk: one read issued per step while bytes remain, its data registered in rd_data_ff
         if (state_ff == ST_CHECK || state_ff == ST_RAW_BODY || state_ff == ST_DECODE) begin
            rd_en      = rd_idx_ff < count_ff;
            rd_idx_in  = rd_en ? rd_idx_ff + CW'(1) : rd_idx_ff;
            rd_ok_in   = rd_en;
            rd_last_in = rd_en && (rd_idx_ff == count_ff - CW'(1));
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (!fifo_empty) begin
                  pop = 1'b1;
                  unique case (cmd.kind)
                     mu7d_pkg::CMD_PASS: begin
                        rsp_valid_in = 1'b1;
                        rsp_byte_in  = cmd.data;
                        rsp_bv_in    = 1'b1;
                        rsp_last_in  = 1'b1;
                        rsp_done_in  = cmd.last;
                        rsp_ovf_in   = 1'b0;
                        if (cmd.last) begin
                           count_in = '0;
                           ovf_in   = 1'b0;
                        end
                     end
                     mu7d_pkg::CMD_OPEN: begin
                        count_in = '0;
                        ovf_in   = 1'b0;
                     end
                     mu7d_pkg::CMD_STORE: begin
                        if (count_ff < CW'(MAX_BODY)) begin
                           wr_en    = 1'b1;
                           count_in = count_ff + CW'(1);
                        end else begin
                           ovf_in = 1'b1;
                        end
                        if (cmd.last) begin
                           state_in   = ST_CHECK;
                           dash_in    = 1'b0;
                           end_in     = 1'b1;
                           run_ovf_in = ovf_ff || (count_ff >= CW'(MAX_BODY));
                           rd_idx_in  = '0;
                           rd_ok_in   = 1'b0;
                        end
                     end
                     mu7d_pkg::CMD_CLOSE: begin
                        if (count_ff == '0) begin
                           rsp_valid_in = 1'b1;
                           rsp_byte_in  = mu7d_pkg::CHAR_AMP;
                           rsp_bv_in    = 1'b1;
                           rsp_last_in  = 1'b1;
                           rsp_done_in  = cmd.last;
                           rsp_ovf_in   = ovf_ff;
                           ovf_in       = 1'b0;
                        end else begin
                           state_in   = ST_CHECK;
                           dash_in    = 1'b1;
                           end_in     = cmd.last;
                           run_ovf_in = ovf_ff;
                           rd_idx_in  = '0;
                           rd_ok_in   = 1'b0;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_CHECK: begin
               if (rd_ok_ff) begin
                  if (!digit[6]) begin
                     state_in  = ST_RAW_AMP;
                     rd_idx_in = '0;
                     rd_ok_in  = 1'b0;
                  end else if (rd_last_ff) begin
                     state_in      = ST_DECODE;
                     rd_idx_in     = '0;
                     rd_ok_in      = 1'b0;
                     acc_in        = '0;
                     bits_in       = '0;
                     have_hi_in    = 1'b0;
                     pend_valid_in = 1'b0;
                  end
               end
            end
            ST_RAW_AMP: begin
               put_en   = 1'b1;
               put_val  = mu7d_pkg::CHAR_AMP;
               state_in = ST_RAW_BODY;
            end
            ST_RAW_BODY: begin
               if (rd_ok_ff) begin
                  put_en  = 1'b1;
                  put_val = rd_data_ff;
                  if (rd_last_ff) begin
                     state_in = dash_ff ? ST_RAW_DASH : ST_FIN;
                  end
               end
            end
            ST_RAW_DASH: begin
               put_en   = 1'b1;
               put_val  = mu7d_pkg::CHAR_DASH;
               state_in = ST_FIN;
            end
            ST_DECODE: begin
               if (rd_ok_ff) begin
                  acc_in        = acc_next;
                  bits_in       = byte_ready ? byte_shift : bits_sum[2:0];
                  pend_in       = u_pend;
                  pend_valid_in = u_pend_valid;
                  if (byte_ready) begin
                     hi_in      = new_byte;
                     have_hi_in = !have_hi_ff;
                  end
                  if (u_emit) begin
                     cp_in    = u_cp;
                     len_in   = mu7d_pkg::utf8_len(u_cp);
                     pos_in   = '0;
                     state_in = ST_EMIT;
                     ret_in   = rd_last_ff ? ST_FLUSH : ST_DECODE;
                  end else if (rd_last_ff) begin
                     state_in = ST_FLUSH;
                  end
               end
            end
            ST_EMIT: begin
               put_en  = 1'b1;
               put_val = mu7d_pkg::utf8_byte(cp_ff, len_ff, pos_ff);
               pos_in  = pos_ff + 2'd1;
               if (pos_ff == len_ff) begin
                  state_in = ret_ff;
               end
            end
            ST_FLUSH: begin
               // lone high surrogate at the end goes out as three bytes
               if (pend_valid_ff) begin
                  cp_in         = {5'b00000, pend_ff};
                  len_in        = 2'd2;
                  pos_in        = '0;
                  pend_valid_in = 1'b0;
                  state_in      = ST_EMIT;
                  ret_in        = ST_FIN;
               end else begin
                  state_in = ST_FIN;
               end
            end
            ST_FIN: begin
               fin_en   = 1'b1;
               count_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase

         // one byte held back so the last one of a run can be marked
         if (put_en) begin
            if (hold_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = hold_byte_ff;
               rsp_bv_in    = 1'b1;
               rsp_last_in  = 1'b0;
               rsp_done_in  = 1'b0;
               rsp_ovf_in   = run_ovf_ff;
            end
            hold_valid_in = 1'b1;
            hold_byte_in  = put_val;
         end

         if (fin_en) begin
            if (hold_valid_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = hold_byte_ff;
               rsp_bv_in     = 1'b1;
               rsp_last_in   = 1'b1;
               rsp_done_in   = end_ff;
               rsp_ovf_in    = run_ovf_ff;
               hold_valid_in = 1'b0;
            end else if (end_ff) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = '0;
               rsp_bv_in    = 1'b0;
               rsp_last_in  = 1'b1;
               rsp_done_in  = 1'b1;
               rsp_ovf_in   = run_ovf_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         body_mem[count_ff[AW-1:0]] <= cmd.data;
      end
      if (rd_en) begin
         rd_data_ff <= body_mem[rd_idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ret_ff        <= ST_IDLE;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         rd_ok_ff      <= 1'b0;
         rd_last_ff    <= 1'b0;
         have_hi_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         count_ff      <= count_in;
         ovf_ff        <= ovf_in;
         rd_ok_ff      <= rd_ok_in;
         rd_last_ff    <= rd_last_in;
         have_hi_ff    <= have_hi_in;
         pend_valid_ff <= pend_valid_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      run_ovf_ff   <= run_ovf_in;
      dash_ff      <= dash_in;
      end_ff       <= end_in;
      rd_idx_ff    <= rd_idx_in;
      acc_ff       <= acc_in;
      bits_ff      <= bits_in;
      hi_ff        <= hi_in;
      pend_ff      <= pend_in;
      cp_ff        <= cp_in;
      len_ff       <= len_in;
      pos_ff       <= pos_in;
      hold_byte_ff <= hold_byte_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_bv_ff    <= rsp_bv_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_byte_valid  = rsp_bv_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_name_done   = rsp_done_ff;
   assign rsp_overflow    = rsp_ovf_ff;

endmodule

### src/modified_utf7_decoder_top.sv
// top level of the modified utf-7 mailbox name decoder
//
//   channel  dir  beat                                     handshake
//   req      in   in_byte, end_of_name                     req_valid / req_stall
//   rsp      out  out_byte, byte_valid, last_of_run,        rsp_valid / rsp_stall
//                 name_done, overflow
//
// a plain byte is passed on in the idle state, queued behind a four-entry command queue
// closing a shift walks the body store through its single read port, once to check it
// and once to decode or copy it; reset clears the queue, the fsm and valid flags, and
// the body store needs no clearing pass; rsp_stall freezes the back end while rsp_valid
// is set, and req_stall rises only while the queue is full
`timescale 1ns / 1ps

module modified_utf7_decoder_top #(
   parameter int MAX_BODY = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_name,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_last_of_run,
   output logic       rsp_name_done,
   output logic       rsp_overflow
);

   logic              push;
   logic              pop;
   logic              fifo_full;
   logic              fifo_empty;
   mu7d_pkg::cmd_type push_cmd;
   mu7d_pkg::cmd_type pop_cmd;

   mu7d_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_end_of_name (req_end_of_name),
      .fifo_full       (fifo_full),
      .push            (push),
      .push_cmd        (push_cmd)
   );

   mu7d_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (fifo_full),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .empty    (fifo_empty)
   );

   mu7d_back #(
      .MAX_BODY (MAX_BODY)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .fifo_empty      (fifo_empty),
      .cmd             (pop_cmd),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_name_done   (rsp_name_done),
      .rsp_overflow    (rsp_overflow)
   );

endmodule

### src/mu7d_checker.sv
// port checker for the decoder top level and its bind
`timescale 1ns / 1ps
`include "modified_utf7_decoder_top_defines.svh"

module mu7d_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_last_of_run,
   input logic       rsp_name_done,
   input logic       rsp_overflow
);

   logic [11:0] rsp_beat;

   assign rsp_beat = {rsp_out_byte, rsp_byte_valid, rsp_last_of_run, rsp_name_done, rsp_overflow};

   `MU7D_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_beat), "rsp beat changed while stalled")
   `MU7D_ASSERT(a_done_is_last, rsp_valid && rsp_name_done |-> rsp_last_of_run, "name end not marked as last of run")
   `MU7D_ASSERT(a_marker_shape, rsp_valid && !rsp_byte_valid |-> rsp_out_byte == 8'h00 && rsp_name_done, "empty marker malformed")
   `MU7D_ASSERT_RST(a_reset_quiet, reset |=> !rsp_valid, "rsp valid right after reset")

endmodule

bind modified_utf7_decoder_top mu7d_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_byte_valid  (rsp_byte_valid),
   .rsp_last_of_run (rsp_last_of_run),
   .rsp_name_done   (rsp_name_done),
   .rsp_overflow    (rsp_overflow)
);

### tb/mu7d_utf8_check.sv
// watches both channels of the decoder, predicts the utf-8 beats and compares them
`timescale 1ns / 1ps

module mu7d_utf8_check #(
   parameter int MAX_BODY = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_name,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_byte_valid,
   input  logic       rsp_last_of_run,
   input  logic       rsp_name_done,
   input  logic       rsp_overflow,
   output int         error_count,
   output int         pending
);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last_of_run;
      logic       name_done;
      logic       overflow;
   } utf8_beat_type;

   utf8_beat_type utf8_due[$];
   utf8_beat_type run_beats[$];

   logic       shift_open = 1'b0;
   logic [7:0] body_mem [MAX_BODY];
   int         body_len = 0;
   logic       body_lost = 1'b0;
   logic       run_ovf = 1'b0;
   int         errs = 0;

   function automatic void emit(input logic [7:0] b);
      utf8_beat_type e;
      e.out_byte    = b;
      e.byte_valid  = 1'b1;
      e.last_of_run = 1'b0;
      e.name_done   = 1'b0;
      e.overflow    = run_ovf;
      run_beats.insert(run_beats.size(), e);
   endfunction

   function automatic int b64_value(input logic [7:0] c);
      if (c >= mu7d_pkg::CHAR_UPPER_A && c <= mu7d_pkg::CHAR_UPPER_Z)
         return int'(c - mu7d_pkg::CHAR_UPPER_A);
      if (c >= mu7d_pkg::CHAR_LOWER_A && c <= mu7d_pkg::CHAR_LOWER_Z)
         return int'(c - mu7d_pkg::CHAR_LOWER_A) + 26;
      if (c >= mu7d_pkg::CHAR_ZERO && c <= mu7d_pkg::CHAR_NINE)
         return int'(c - mu7d_pkg::CHAR_ZERO) + 52;
      if (c == mu7d_pkg::CHAR_PLUS) return 62;
      if (c == mu7d_pkg::CHAR_COMMA) return 63;
      return -1;
   endfunction

   function automatic void emit_code_point(input logic [20:0] cp);
      if (cp < 21'h80) begin
         emit(cp[7:0]);
      end else if (cp < 21'h800) begin
         emit(mu7d_pkg::UTF8_LEAD2 | 8'(cp >> 6));
         emit(mu7d_pkg::UTF8_CONT | {2'b00, cp[5:0]});
      end else if (cp < mu7d_pkg::CP_PLANE1) begin
         emit(mu7d_pkg::UTF8_LEAD3 | 8'(cp >> 12));
         emit(mu7d_pkg::UTF8_CONT | {2'b00, cp[11:6]});
         emit(mu7d_pkg::UTF8_CONT | {2'b00, cp[5:0]});
      end else begin
         emit(mu7d_pkg::UTF8_LEAD4 | 8'(cp >> 18));
         emit(mu7d_pkg::UTF8_CONT | {2'b00, cp[17:12]});
         emit(mu7d_pkg::UTF8_CONT | {2'b00, cp[11:6]});
         emit(mu7d_pkg::UTF8_CONT | {2'b00, cp[5:0]});
      end
   endfunction

   function automatic void decode_body(input logic dash);
      logic [7:0]  octets[$];
      logic [13:0] acc;
      int          nbits;
      int          v;
      int          i;
      logic        good;
      logic [15:0] unit;
      logic [15:0] lo;
      logic [20:0] cp;
      run_ovf = body_lost;
      if (body_len == 0) begin
         emit(mu7d_pkg::CHAR_AMP);
         return;
      end
      acc   = '0;
      nbits = 0;
      good  = 1'b1;
      for (i = 0; i < body_len; i++) begin
         v = b64_value(body_mem[i]);
         if (v < 0) begin
            good = 1'b0;
            break;
         end
         acc   = {acc[7:0], 6'(v)};
         nbits += 6;
         if (nbits >= 8) begin
            nbits -= 8;
            octets.insert(octets.size(), 8'(acc >> nbits));
         end
      end
      if (!good) begin
         emit(mu7d_pkg::CHAR_AMP);
         for (i = 0; i < body_len; i++) emit(body_mem[i]);
         if (dash) emit(mu7d_pkg::CHAR_DASH);
         return;
      end
      // utf-16be units, odd trailing octet dropped
      i = 0;
      while (i + 1 < octets.size()) begin
         unit = {octets[i], octets[i + 1]};
         if (unit >= mu7d_pkg::HIGH_FIRST && unit <= mu7d_pkg::HIGH_LAST
             && i + 3 < octets.size()) begin
            lo = {octets[i + 2], octets[i + 3]};
            if (lo >= mu7d_pkg::LOW_FIRST && lo <= mu7d_pkg::LOW_LAST) begin
               cp = mu7d_pkg::CP_PLANE1 + (21'(unit - mu7d_pkg::HIGH_FIRST) << 10)
                    + 21'(lo - mu7d_pkg::LOW_FIRST);
               emit_code_point(cp);
               i += 4;
            end else begin
               i += 2;
            end
         end else if (unit >= mu7d_pkg::LOW_FIRST && unit <= mu7d_pkg::LOW_LAST) begin
            i += 2;
         end else begin
            emit_code_point({5'b00000, unit});
            i += 2;
         end
      end
   endfunction

   function automatic void take_name_byte(input logic [7:0] b, input logic fin);
      utf8_beat_type e;
      run_beats.delete();
      run_ovf = 1'b0;
      if (!shift_open) begin
         if (b == mu7d_pkg::CHAR_AMP) begin
            shift_open = 1'b1;
            body_len   = 0;
            body_lost  = 1'b0;
            if (fin) begin
               decode_body(1'b0);
               shift_open = 1'b0;
            end
         end else begin
            emit(b);
         end
      end else if (b == mu7d_pkg::CHAR_DASH) begin
         decode_body(1'b1);
         shift_open = 1'b0;
         body_len   = 0;
         body_lost  = 1'b0;
      end else begin
         if (body_len < MAX_BODY) begin
            body_mem[body_len] = b;
            body_len++;
         end else begin
            body_lost = 1'b1;
         end
         if (fin) begin
            decode_body(1'b0);
            shift_open = 1'b0;
         end
      end
      if (fin) begin
         if (run_beats.size() == 0) begin
            e          = '0;
            e.overflow = run_ovf;
            run_beats.insert(run_beats.size(), e);
         end
         run_beats[run_beats.size() - 1].name_done = 1'b1;
         shift_open = 1'b0;
         body_len   = 0;
         body_lost  = 1'b0;
      end
      if (run_beats.size() > 0) begin
         run_beats[run_beats.size() - 1].last_of_run = 1'b1;
      end
      foreach (run_beats[k]) utf8_due.insert(utf8_due.size(), run_beats[k]);
   endfunction

   always @(posedge clock) begin : watch
      utf8_beat_type want;
      if (reset) begin
         shift_open = 1'b0;
         body_len   = 0;
         body_lost  = 1'b0;
         utf8_due.delete();
         errs = 0;
      end else begin
         if (req_valid && !req_stall) take_name_byte(req_in_byte, req_end_of_name);
         if (rsp_valid && !rsp_stall) begin
            if (utf8_due.size() == 0) begin
               $error("unexpected result beat: out_byte %h", rsp_out_byte);
               errs++;
            end else begin
               want = utf8_due.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte: expected %h, actual %h", want.out_byte, rsp_out_byte);
                  errs++;
               end
               if (rsp_byte_valid !== want.byte_valid) begin
                  $error("byte_valid: expected %b, actual %b", want.byte_valid,
                         rsp_byte_valid);
                  errs++;
               end
               if (rsp_last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %b, actual %b", want.last_of_run,
                         rsp_last_of_run);
                  errs++;
               end
               if (rsp_name_done !== want.name_done) begin
                  $error("name_done: expected %b, actual %b", want.name_done, rsp_name_done);
                  errs++;
               end
               if (rsp_overflow !== want.overflow) begin
                  $error("overflow: expected %b, actual %b", want.overflow, rsp_overflow);
                  errs++;
               end
            end
         end
      end
      pending     <= utf8_due.size();
      error_count <= errs;
   end

endmodule

### tb/tb_top.sv
// stimulus and verdict for the modified utf-7 mailbox name decoder
`timescale 1ns / 1ps

module tb_top;

   localparam int MAX_BODY     = 32;
   localparam int RANDOM_BEATS = 300;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_end_of_name = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_last_of_run;
   logic       rsp_name_done;
   logic       rsp_overflow;

   int error_count;
   int pending;
   int idle_pct = 0;
   int stall_pct = 0;
   int beats_sent = 0;

   logic [7:0]  name_buf[$];
   logic [15:0] unit_buf[$];

   modified_utf7_decoder_top #(
      .MAX_BODY(MAX_BODY)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .req_end_of_name(req_end_of_name),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last_of_run(rsp_last_of_run),
      .rsp_name_done  (rsp_name_done),
      .rsp_overflow   (rsp_overflow)
   );

   mu7d_utf8_check #(
      .MAX_BODY(MAX_BODY)
   ) u_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .req_end_of_name(req_end_of_name),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last_of_run(rsp_last_of_run),
      .rsp_name_done  (rsp_name_done),
      .rsp_overflow   (rsp_overflow),
      .error_count    (error_count),
      .pending        (pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      if (v < 26) return mu7d_pkg::CHAR_UPPER_A + 8'(v);
      if (v < 52) return mu7d_pkg::CHAR_LOWER_A + 8'(v - 26);
      if (v < 62) return mu7d_pkg::CHAR_ZERO + 8'(v - 52);
      if (v == 62) return mu7d_pkg::CHAR_PLUS;
      return mu7d_pkg::CHAR_COMMA;
   endfunction

   function automatic void add_byte(input logic [7:0] b);
      name_buf.insert(name_buf.size(), b);
   endfunction

   function automatic void add_text(input string s);
      int k;
      for (k = 0; k < s.len(); k++) add_byte(s[k]);
   endfunction

   // packs the queued utf-16 units into modified base64 digits
   function automatic void add_units();
      logic [31:0] acc;
      int          nbits;
      acc   = '0;
      nbits = 0;
      foreach (unit_buf[k]) begin
         acc   = (acc << 16) | {16'h0000, unit_buf[k]};
         nbits += 16;
         while (nbits >= 6) begin
            nbits -= 6;
            add_byte(b64_char(6'(acc >> nbits)));
         end
      end
      if (nbits > 0) add_byte(b64_char(6'(acc << (6 - nbits))));
      unit_buf.delete();
   endfunction

   function automatic void add_unit(input logic [15:0] u);
      unit_buf.insert(unit_buf.size(), u);
   endfunction

   function automatic void add_rand_char();
      int          pick;
      logic [15:0] u;
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
         add_unit(16'($urandom_range(0, 16'h7F)));
      end else if (pick < 5) begin
         add_unit(16'($urandom_range(16'h80, 16'h7FF)));
      end else if (pick < 7) begin
         u = 16'($urandom_range(16'h800, 16'hF7FF));
         if (u >= mu7d_pkg::HIGH_FIRST) u = u + 16'h800;
         add_unit(u);
      end else if (pick < 9) begin
         add_unit(16'($urandom_range(mu7d_pkg::HIGH_FIRST, mu7d_pkg::HIGH_LAST)));
         add_unit(16'($urandom_range(mu7d_pkg::LOW_FIRST, mu7d_pkg::LOW_LAST)));
      end else begin
         add_unit(16'($urandom_range(mu7d_pkg::HIGH_FIRST, mu7d_pkg::LOW_LAST)));
      end
   endfunction

   task automatic send_beat(input logic [7:0] b, input logic fin);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_in_byte     <= b;
      req_end_of_name <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      beats_sent++;
   endtask

   task automatic send_name();
      int k;
      for (k = 0; k < name_buf.size(); k++) send_beat(name_buf[k], k == name_buf.size() - 1);
      name_buf.delete();
   endtask

   task automatic send_random_name();
      int   kind;
      int   nseg;
      int   n;
      int   s;
      logic [7:0] b;
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
         nseg = $urandom_range(1, 4);
         for (s = 0; s < nseg; s++) begin
            if ($urandom_range(0, 2) == 0) begin
               if ($urandom_range(0, 9) == 0) begin
                  add_text("&-");
               end else begin
                  repeat ($urandom_range(1, 4)) begin
                     do b = 8'($urandom_range(32, 126)); while (b == mu7d_pkg::CHAR_AMP);
                     add_byte(b);
                  end
               end
            end else begin
               add_byte(mu7d_pkg::CHAR_AMP);
               repeat ($urandom_range(1, 4)) add_rand_char();
               add_units();
               if (s != nseg - 1 || $urandom_range(0, 9) != 0) add_byte(mu7d_pkg::CHAR_DASH);
            end
         end
      end else if (kind < 57) begin
         // body around the store size, some of it past the end
         add_byte(mu7d_pkg::CHAR_AMP);
         n = $urandom_range(11, 14);
         while (unit_buf.size() < n) add_rand_char();
         add_units();
         if ($urandom_range(0, 9) < 3) begin
            name_buf[$urandom_range(1, name_buf.size() - 1)] =
               ($urandom_range(0, 1) == 0) ? 8'h21 : 8'($urandom_range(128, 255));
         end
         if ($urandom_range(0, 1) == 0) add_byte(mu7d_pkg::CHAR_DASH);
      end else if (kind < 80) begin
         add_byte(mu7d_pkg::CHAR_AMP);
         repeat ($urandom_range(0, 10)) add_byte(b64_char(6'($urandom_range(0, 63))));
         if ($urandom_range(0, 1) == 0) add_byte(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 9) < 6) add_byte(mu7d_pkg::CHAR_DASH);
      end else begin
         repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
      end
      send_name();
   endtask

   initial begin : stimulus
      int directed;
      int p;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      add_byte(8'h00);
      add_byte(8'hFF);
      send_name();
      add_text("&-");
      send_name();
      add_text("&");
      send_name();
      // lone low, surrogate pair, high before a plain unit, high at the very end
      add_byte(mu7d_pkg::CHAR_AMP);
      unit_buf = '{16'hDC00, 16'hD83D, 16'hDE00, 16'hD800, 16'h0041, 16'hD800};
      add_units();
      add_byte(mu7d_pkg::CHAR_DASH);
      send_name();
      add_text("&A!");
      send_name();
      add_text("&AA");
      send_name();
      directed = beats_sent;

      for (p = 0; p < 4; p++) begin
         case (p)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 65;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 65;
            end
            default: begin
               idle_pct  = 16;
               stall_pct = 16;
            end
         endcase
         while (beats_sent < directed + (RANDOM_BEATS * (p + 1)) / 4) send_random_name();
      end
      req_valid <= 1'b0;

      wait (pending == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin : watchdog
      #12_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
